/* rtl/bpd_pkg.sv */
package bpd_pkg;

	// field and register widths
	localparam int TOT_BITS      = 63;
	localparam int LEN_PORT_BITS = 32;
	localparam int BW_BITS       = 40;
	localparam int CFG_IDX_BITS  = 2;
	localparam int NS_BITS       = 30;

	localparam logic [NS_BITS-1:0]  NS_PER_SEC = 30'd1000000000;
	localparam logic [BW_BITS-1:0]  BW_RESET   = 40'd1000000000;
	localparam logic [TOT_BITS-1:0] TOTAL_MAX  = {TOT_BITS{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_WR_BW = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RD_BW = 2'd1;

	typedef enum logic [1:0] {
		OP_WR_START = 2'd0,
		OP_WR_DONE  = 2'd1,
		OP_RD_START = 2'd2,
		OP_RD_DONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WAIT,
		ST_DELAY,
		ST_FREE,
		ST_DTOT,
		ST_BYTES,
		ST_COUNT,
		ST_FINISH
	} state_t;

endpackage

/* rtl/bpd_div.sv */
// Restoring divider, one quotient bit per cycle.
module bpd_div #(
	parameter int DIVIDEND_BITS = 62,
	parameter int DIVISOR_BITS  = 40
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [DIVISOR_BITS-1:0]  divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_BITS + 1);

	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  dvs_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [CW-1:0]            cnt_q;
	logic                     busy_q;
	logic                     done_q;

	logic [DIVISOR_BITS:0]   rem_sh;
	logic [DIVISOR_BITS+1:0] diff;
	logic                    ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIVIDEND_BITS-1]};
		diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
		ge     = ~diff[DIVISOR_BITS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* rtl/bandwidth_pipe_delay_model.sv */
// Bandwidth-limited storage pipe delay model. Separate write and read channels each
// hold the time at which they are next free; a start request returns the wait until
// the channel is free plus length * 1e9 / bandwidth (truncated, saturating at the
// top of the time range, all-ones for a zero bandwidth), and moves the channel's
// free time to now + delay. Done requests return an acknowledge (length 0 for write
// done, the request length for read done). Every result also carries saturating
// running totals of counts, bytes and delays. One request is in flight at a time:
// a start request runs through the shared restoring divider, which produces one
// quotient bit per cycle, and then through the shared saturating adder; a read done
// uses the adder for its byte total and count, and a write done goes straight to the result.
// in_ready is low while a request is in progress and while a result waits to be
// taken. Bandwidth registers are written through the cfg port (index 0 write,
// index 1 read; other indexes are ignored), always ready.
module bandwidth_pipe_delay_model #(
	parameter int TIME_BITS   = 63,
	parameter int LENGTH_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            operation,
	input  logic [bpd_pkg::TOT_BITS-1:0]          now_ns,
	input  logic [bpd_pkg::LEN_PORT_BITS-1:0]     length_bytes,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [1:0]                            result_kind,
	output logic [bpd_pkg::TOT_BITS-1:0]          delay_ns,
	output logic [bpd_pkg::LEN_PORT_BITS-1:0]     return_length,
	output logic [bpd_pkg::TOT_BITS-1:0]          writes_done,
	output logic [bpd_pkg::TOT_BITS-1:0]          reads_done,
	output logic [bpd_pkg::TOT_BITS-1:0]          bytes_out_written,
	output logic [bpd_pkg::TOT_BITS-1:0]          bytes_out_read,
	output logic [bpd_pkg::TOT_BITS-1:0]          write_delay_sum,
	output logic [bpd_pkg::TOT_BITS-1:0]          read_delay_sum,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bpd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [bpd_pkg::BW_BITS-1:0]           cfg_data
);

	localparam int TB = bpd_pkg::TOT_BITS;
	localparam int QW = LENGTH_BITS + bpd_pkg::NS_BITS;   // product / quotient width
	localparam logic [TB-1:0] TMAX_TOT = TB'((64'd1 << TIME_BITS) - 64'd1);

	bpd_pkg::state_t state_q, state_d;

	// request held for the whole sequence
	bpd_pkg::op_t           op_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [LENGTH_BITS-1:0] len_q;

	// per-request working values
	logic [TIME_BITS-1:0] xfer_q;
	logic [TIME_BITS-1:0] wait_q;
	logic [TIME_BITS-1:0] delay_q;

	// channel state and totals
	logic [TIME_BITS-1:0]         wr_free_q, rd_free_q;
	logic [TB-1:0]                wr_cnt_q, rd_cnt_q;
	logic [TB-1:0]                wr_bytes_q, rd_bytes_q;
	logic [TB-1:0]                wr_dsum_q, rd_dsum_q;
	logic [bpd_pkg::BW_BITS-1:0]  wr_bw_q, rd_bw_q;
	logic                         out_valid_q;

	logic in_xfer;
	logic is_rd;
	logic is_wr_start;
	logic [bpd_pkg::BW_BITS-1:0] bw_sel;

	// divider
	logic          div_start;
	logic          div_done;
	logic [QW-1:0] div_quo;
	logic [QW-1:0] product;

	// shared saturating adder / floored subtractor
	logic [TB-1:0] alu_a, alu_b, alu_top, alu_res;
	logic          alu_sub;
	logic [TB:0]   alu_sum;

	// transfer-time clamp
	logic [TIME_BITS-1:0] xfer_new;

	assign in_ready    = (state_q == bpd_pkg::ST_IDLE) && !out_valid_q;
	assign in_xfer     = in_valid && in_ready;
	assign cfg_ready   = 1'b1;
	assign is_rd       = (op_q == bpd_pkg::OP_RD_START);
	assign is_wr_start = (op_q == bpd_pkg::OP_WR_START);
	assign bw_sel      = is_rd ? rd_bw_q : wr_bw_q;

	// multiply registers into the divider's dividend register
	assign product   = QW'(len_q) * QW'(bpd_pkg::NS_PER_SEC);
	assign div_start = (state_q == bpd_pkg::ST_MUL);

	bpd_div #(
		.DIVIDEND_BITS(QW),
		.DIVISOR_BITS (bpd_pkg::BW_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(product),
		.divisor (bw_sel),
		.done    (div_done),
		.quotient(div_quo)
	);

	// zero bandwidth means an unbounded transfer time; otherwise clamp to the time range
	always_comb begin
		if (bw_sel == '0) begin
			xfer_new = '1;
		end else if (64'(div_quo) > 64'(TMAX_TOT)) begin
			xfer_new = '1;
		end else begin
			xfer_new = TIME_BITS'(div_quo);
		end
	end

	// operand selection for the shared adder, and next state
	always_comb begin
		state_d = state_q;
		alu_a   = '0;
		alu_b   = '0;
		alu_top = bpd_pkg::TOTAL_MAX;
		alu_sub = 1'b0;
		unique case (state_q)
			bpd_pkg::ST_IDLE: begin
				if (in_xfer) begin
					unique case (bpd_pkg::op_t'(operation))
						bpd_pkg::OP_WR_START,
						bpd_pkg::OP_RD_START: state_d = bpd_pkg::ST_MUL;
						bpd_pkg::OP_WR_DONE:  state_d = bpd_pkg::ST_FINISH;
						bpd_pkg::OP_RD_DONE:  state_d = bpd_pkg::ST_BYTES;
						default:              state_d = bpd_pkg::ST_FINISH;
					endcase
				end
			end
			bpd_pkg::ST_MUL: state_d = bpd_pkg::ST_DIV;
			bpd_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = bpd_pkg::ST_WAIT;
				end
			end
			bpd_pkg::ST_WAIT: begin
				// wait = free > now ? free - now : 0
				alu_a   = TB'(is_rd ? rd_free_q : wr_free_q);
				alu_b   = TB'(now_q);
				alu_sub = 1'b1;
				state_d = bpd_pkg::ST_DELAY;
			end
			bpd_pkg::ST_DELAY: begin
				alu_a   = TB'(wait_q);
				alu_b   = TB'(xfer_q);
				alu_top = TMAX_TOT;
				state_d = bpd_pkg::ST_FREE;
			end
			bpd_pkg::ST_FREE: begin
				alu_a   = TB'(now_q);
				alu_b   = TB'(delay_q);
				alu_top = TMAX_TOT;
				state_d = bpd_pkg::ST_DTOT;
			end
			bpd_pkg::ST_DTOT: begin
				alu_a   = is_rd ? rd_dsum_q : wr_dsum_q;
				alu_b   = TB'(delay_q);
				state_d = is_wr_start ? bpd_pkg::ST_BYTES : bpd_pkg::ST_FINISH;
			end
			bpd_pkg::ST_BYTES: begin
				alu_a   = is_wr_start ? wr_bytes_q : rd_bytes_q;
				alu_b   = TB'(len_q);
				state_d = bpd_pkg::ST_COUNT;
			end
			bpd_pkg::ST_COUNT: begin
				alu_a   = is_wr_start ? wr_cnt_q : rd_cnt_q;
				alu_b   = TB'(1);
				state_d = bpd_pkg::ST_FINISH;
			end
			bpd_pkg::ST_FINISH: state_d = bpd_pkg::ST_IDLE;
			default:            state_d = bpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		if (alu_sub) begin
			alu_sum = {1'b0, alu_a} - {1'b0, alu_b};
			alu_res = alu_sum[TB] ? '0 : alu_sum[TB-1:0];
		end else begin
			alu_sum = {1'b0, alu_a} + {1'b0, alu_b};
			alu_res = (alu_sum > {1'b0, alu_top}) ? alu_top : alu_sum[TB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control, channel state and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			wr_free_q   <= '0;
			rd_free_q   <= '0;
			wr_cnt_q    <= '0;
			rd_cnt_q    <= '0;
			wr_bytes_q  <= '0;
			rd_bytes_q  <= '0;
			wr_dsum_q   <= '0;
			rd_dsum_q   <= '0;
			wr_bw_q     <= bpd_pkg::BW_RESET;
			rd_bw_q     <= bpd_pkg::BW_RESET;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == bpd_pkg::CFG_WR_BW) begin
					wr_bw_q <= cfg_data;
				end else if (cfg_index == bpd_pkg::CFG_RD_BW) begin
					rd_bw_q <= cfg_data;
				end
			end

			if (state_q == bpd_pkg::ST_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				bpd_pkg::ST_FREE: begin
					if (is_rd) begin
						rd_free_q <= TIME_BITS'(alu_res);
					end else begin
						wr_free_q <= TIME_BITS'(alu_res);
					end
				end
				bpd_pkg::ST_DTOT: begin
					if (is_rd) begin
						rd_dsum_q <= alu_res;
					end else begin
						wr_dsum_q <= alu_res;
					end
				end
				bpd_pkg::ST_BYTES: begin
					if (is_wr_start) begin
						wr_bytes_q <= alu_res;
					end else begin
						rd_bytes_q <= alu_res;
					end
				end
				bpd_pkg::ST_COUNT: begin
					if (is_wr_start) begin
						wr_cnt_q <= alu_res;
					end else begin
						rd_cnt_q <= alu_res;
					end
				end
				default: ;
			endcase
		end
	end

	// request payload and working values
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q    <= bpd_pkg::op_t'(operation);
			now_q   <= now_ns[TIME_BITS-1:0];
			len_q   <= length_bytes[LENGTH_BITS-1:0];
			delay_q <= '0;     // done requests report no delay
		end
		if (state_q == bpd_pkg::ST_DIV && div_done) begin
			xfer_q <= xfer_new;
		end
		if (state_q == bpd_pkg::ST_WAIT) begin
			wait_q <= TIME_BITS'(alu_res);
		end
		if (state_q == bpd_pkg::ST_DELAY) begin
			delay_q <= TIME_BITS'(alu_res);
		end
	end

	// results come straight from the held registers; nothing moves while out_valid is high
	assign out_valid         = out_valid_q;
	assign result_kind       = op_q;
	assign delay_ns          = TB'(delay_q);
	assign return_length     = (op_q == bpd_pkg::OP_WR_DONE) ? '0
	                         : bpd_pkg::LEN_PORT_BITS'(len_q);
	assign writes_done       = wr_cnt_q;
	assign reads_done        = rd_cnt_q;
	assign bytes_out_written = wr_bytes_q;
	assign bytes_out_read    = rd_bytes_q;
	assign write_delay_sum   = wr_dsum_q;
	assign read_delay_sum    = rd_dsum_q;

endmodule

/* bench/bandwidth_pipe_delay_model_test.sv */
`timescale 1ns / 1ps

module bandwidth_pipe_delay_model_test;

	// run limits
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          DRAIN_CYCLES = 80;    // a bit over one start request
	localparam int          PHASE_ITEMS = 300;
	localparam int          PHASES = 6;

	// index outside the register map, written once to see that it is dropped
	localparam logic [bpd_pkg::CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;

	localparam logic [bpd_pkg::BW_BITS-1:0] BW_ONE_GBS = 40'd1000000000;
	localparam logic [bpd_pkg::BW_BITS-1:0] BW_TOP     = 40'd1000000000000;
	localparam logic [62:0]                 T_END      = bpd_pkg::TOTAL_MAX;

	// one result transfer, as seen on the output ports
	typedef struct {
		logic [1:0]                        kind;
		logic [bpd_pkg::TOT_BITS-1:0]      delay;
		logic [bpd_pkg::LEN_PORT_BITS-1:0] ret_len;
		logic [bpd_pkg::TOT_BITS-1:0]      wr_cnt;
		logic [bpd_pkg::TOT_BITS-1:0]      rd_cnt;
		logic [bpd_pkg::TOT_BITS-1:0]      wr_bytes;
		logic [bpd_pkg::TOT_BITS-1:0]      rd_bytes;
		logic [bpd_pkg::TOT_BITS-1:0]      wr_dly;
		logic [bpd_pkg::TOT_BITS-1:0]      rd_dly;
	} pipe_result_t;

	// Mirror of the pipe state plus the queue of results still owed by the block.
	class pipe_delay_checker;
		logic [bpd_pkg::BW_BITS-1:0]  wr_bw, rd_bw;
		logic [bpd_pkg::TOT_BITS-1:0] wr_free, rd_free;
		logic [bpd_pkg::TOT_BITS-1:0] wr_cnt, rd_cnt, wr_bytes, rd_bytes, wr_dly, rd_dly;
		pipe_result_t                 due_results[$];
		bit                           failed;

		function new();
			wr_bw = bpd_pkg::BW_RESET;
			rd_bw = bpd_pkg::BW_RESET;
			wr_free = '0;
			rd_free = '0;
			wr_cnt = '0;
			rd_cnt = '0;
			wr_bytes = '0;
			rd_bytes = '0;
			wr_dly = '0;
			rd_dly = '0;
			failed = 1'b0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void set_bandwidth(logic [bpd_pkg::CFG_IDX_BITS-1:0] idx,
				logic [bpd_pkg::BW_BITS-1:0] val);
			if (idx == bpd_pkg::CFG_WR_BW) begin
				wr_bw = val;
			end else if (idx == bpd_pkg::CFG_RD_BW) begin
				rd_bw = val;
			end
		endfunction

		// add clamped to the top of the 63-bit range
		function logic [bpd_pkg::TOT_BITS-1:0] sat_sum(logic [bpd_pkg::TOT_BITS-1:0] a,
				logic [63:0] b);
			logic [63:0] s;
			s = {1'b0, a} + b;
			return (s > {1'b0, bpd_pkg::TOTAL_MAX}) ? bpd_pkg::TOTAL_MAX
				: s[bpd_pkg::TOT_BITS-1:0];
		endfunction

		// wait for the channel plus transfer time; advances the channel's free time
		function logic [bpd_pkg::TOT_BITS-1:0] finish_delay(
				inout logic [bpd_pkg::TOT_BITS-1:0] free_at,
				input logic [bpd_pkg::BW_BITS-1:0] bw,
				input logic [bpd_pkg::TOT_BITS-1:0] t,
				input logic [bpd_pkg::LEN_PORT_BITS-1:0] n);
			logic [63:0]                  product, xfer64;
			logic [bpd_pkg::TOT_BITS-1:0] wait_ns, xfer, dly;
			wait_ns = (free_at > t) ? free_at - t : '0;
			if (bw == '0) begin
				xfer = bpd_pkg::TOTAL_MAX;
			end else begin
				product = 64'(n) * 64'd1000000000;
				xfer64 = product / 64'(bw);
				xfer = (xfer64 > {1'b0, bpd_pkg::TOTAL_MAX}) ? bpd_pkg::TOTAL_MAX
					: xfer64[bpd_pkg::TOT_BITS-1:0];
			end
			dly = sat_sum(wait_ns, xfer);
			free_at = sat_sum(t, dly);
			return dly;
		endfunction

		function void log_request(bpd_pkg::op_t op, logic [bpd_pkg::TOT_BITS-1:0] t,
				logic [bpd_pkg::LEN_PORT_BITS-1:0] n);
			pipe_result_t r;
			r.kind = op;
			r.delay = '0;
			r.ret_len = n;
			case (op)
				bpd_pkg::OP_WR_START: begin
					r.delay = finish_delay(wr_free, wr_bw, t, n);
					wr_dly = sat_sum(wr_dly, r.delay);
					wr_bytes = sat_sum(wr_bytes, n);
					wr_cnt = sat_sum(wr_cnt, 1);
				end
				bpd_pkg::OP_WR_DONE: begin
					r.ret_len = '0;
				end
				bpd_pkg::OP_RD_START: begin
					r.delay = finish_delay(rd_free, rd_bw, t, n);
					rd_dly = sat_sum(rd_dly, r.delay);
				end
				default: begin
					rd_bytes = sat_sum(rd_bytes, n);
					rd_cnt = sat_sum(rd_cnt, 1);
				end
			endcase
			r.wr_cnt = wr_cnt;
			r.rd_cnt = rd_cnt;
			r.wr_bytes = wr_bytes;
			r.rd_bytes = rd_bytes;
			r.wr_dly = wr_dly;
			r.rd_dly = rd_dly;
			due_results.push_back(r);
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] seen);
			if (seen !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
				failed = 1'b1;
			end
		endfunction

		function void match_result(pipe_result_t got);
			pipe_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result transfer with none outstanding, kind %0d delay %0d",
					$time, got.kind, got.delay);
				failed = 1'b1;
				return;
			end
			want = due_results.pop_front();
			check_field("result_kind", want.kind, got.kind);
			check_field("delay_ns", want.delay, got.delay);
			check_field("return_length", want.ret_len, got.ret_len);
			check_field("writes_done", want.wr_cnt, got.wr_cnt);
			check_field("reads_done", want.rd_cnt, got.rd_cnt);
			check_field("bytes_out_written", want.wr_bytes, got.wr_bytes);
			check_field("bytes_out_read", want.rd_bytes, got.rd_bytes);
			check_field("write_delay_sum", want.wr_dly, got.wr_dly);
			check_field("read_delay_sum", want.rd_dly, got.rd_dly);
		endfunction
	endclass

	// every block input starts at a known value
	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [1:0]                        operation = bpd_pkg::OP_WR_START;
	logic [bpd_pkg::TOT_BITS-1:0]      now_ns = '0;
	logic [bpd_pkg::LEN_PORT_BITS-1:0] length_bytes = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic [1:0]                        result_kind;
	logic [bpd_pkg::TOT_BITS-1:0]      delay_ns;
	logic [bpd_pkg::LEN_PORT_BITS-1:0] return_length;
	logic [bpd_pkg::TOT_BITS-1:0]      writes_done;
	logic [bpd_pkg::TOT_BITS-1:0]      reads_done;
	logic [bpd_pkg::TOT_BITS-1:0]      bytes_out_written;
	logic [bpd_pkg::TOT_BITS-1:0]      bytes_out_read;
	logic [bpd_pkg::TOT_BITS-1:0]      write_delay_sum;
	logic [bpd_pkg::TOT_BITS-1:0]      read_delay_sum;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [bpd_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [bpd_pkg::BW_BITS-1:0]       cfg_data = '0;

	pipe_delay_checker sb;
	pipe_result_t      seen_result;
	bit                steady = 1'b0;      // no idling on either side while set
	int unsigned       cycle_count = 0;

	bandwidth_pipe_delay_model dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs on either handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result side: check each transfer against the oldest outstanding prediction,
	// then pick ready for the next cycle. Values read here are the pre-edge ones.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_result.kind = result_kind;
			seen_result.delay = delay_ns;
			seen_result.ret_len = return_length;
			seen_result.wr_cnt = writes_done;
			seen_result.rd_cnt = reads_done;
			seen_result.wr_bytes = bytes_out_written;
			seen_result.rd_bytes = bytes_out_read;
			seen_result.wr_dly = write_delay_sum;
			seen_result.rd_dly = read_delay_sum;
			sb.match_result(seen_result);
		end
		out_ready <= steady || ($urandom_range(99) >= 14);
	end

	// One request transfer. A random gap may come first; valid is never dropped
	// and raised again in one step, so back-to-back items keep valid high.
	task automatic send_request(input bpd_pkg::op_t op,
			input logic [bpd_pkg::TOT_BITS-1:0] t,
			input logic [bpd_pkg::LEN_PORT_BITS-1:0] n);
		if (!steady && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 30) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		now_ns <= t;
		length_bytes <= n;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.log_request(op, t, n);
	endtask

	// stop sending and wait until the block owes nothing
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// register write; the caller drops cfg_valid after the last one
	task automatic write_reg(input logic [bpd_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [bpd_pkg::BW_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_bandwidth(idx, val);
	endtask

	task automatic configure(input logic [bpd_pkg::BW_BITS-1:0] wr,
			input logic [bpd_pkg::BW_BITS-1:0] rd);
		write_reg(bpd_pkg::CFG_WR_BW, wr);
		write_reg(bpd_pkg::CFG_RD_BW, rd);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [bpd_pkg::BW_BITS-1:0] rand_bandwidth(
			input int unsigned top_byte);
		int unsigned hi;
		hi = $urandom_range(top_byte);
		return {hi[7:0], 32'($urandom())};
	endfunction

	initial begin
		logic [bpd_pkg::TOT_BITS-1:0]      clock_ns;
		logic [bpd_pkg::LEN_PORT_BITS-1:0] len;
		logic [bpd_pkg::BW_BITS-1:0]       wbw, rbw;
		bpd_pkg::op_t                      op;
		int unsigned                       len_cap, step_cap, hi;

		sb = new();
		clock_ns = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out-of-map index: must leave both bandwidths at their reset value
		write_reg(CFG_SPARE, 40'h55_5555_5555);
		cfg_valid <= 1'b0;

		// --- directed, reset bandwidths (1 GB/s both ways) ---
		send_request(bpd_pkg::OP_WR_START, 63'd0, 32'd0);            // empty transfer
		send_request(bpd_pkg::OP_WR_START, 63'd0, 32'd1000);         // idle pipe, 1000 ns
		send_request(bpd_pkg::OP_WR_START, 63'd500, 32'd1000);       // arrives while busy
		send_request(bpd_pkg::OP_WR_DONE, 63'd600, 32'hFFFF_FFFF);   // ack carries no length
		send_request(bpd_pkg::OP_RD_START, 63'd0, 32'hFFFF_FFFF);    // longest length
		send_request(bpd_pkg::OP_RD_START, 63'd100, 32'd1);
		send_request(bpd_pkg::OP_RD_DONE, T_END, 32'hFFFF_FFFF);
		send_request(bpd_pkg::OP_RD_START, T_END, 32'd10);   // free time clamps at top
		send_request(bpd_pkg::OP_RD_START, 63'd5, 32'd0);    // wait nearly the whole range
		send_request(bpd_pkg::OP_RD_START, T_END, 32'd0);    // free exactly now: no wait
		send_request(bpd_pkg::OP_WR_START, 63'd2000, 32'd7); // write pipe free exactly now
		send_request(bpd_pkg::OP_RD_DONE, 63'd0, 32'd0);
		send_request(bpd_pkg::OP_WR_DONE, T_END, 32'd0);
		drain();

		// slowest write pipe, fastest legal read pipe
		configure(40'd1, BW_TOP);
		send_request(bpd_pkg::OP_WR_START, 63'd0, 32'hFFFF_FFFF);
		send_request(bpd_pkg::OP_WR_START, 63'd0, 32'hFFFF_FFFF);  // delay total saturates
		send_request(bpd_pkg::OP_WR_START, 63'd1, 32'hFFFF_FFFF);  // delay itself saturates
		send_request(bpd_pkg::OP_RD_START, 63'd0, 32'hFFFF_FFFF);
		send_request(bpd_pkg::OP_RD_START, 63'd9000000, 32'd999);  // truncates to zero
		drain();

		// zero bandwidth (transfer time pinned to the top), widest register value
		configure('0, '1);
		send_request(bpd_pkg::OP_WR_START, 63'd0, 32'd0);
		send_request(bpd_pkg::OP_RD_START, 63'd0, 32'hFFFF_FFFF);
		send_request(bpd_pkg::OP_RD_DONE, 63'd12345, 32'hA5A5_5A5A);

		// --- random phases, one bandwidth setting each ---
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
				0: begin
					wbw = BW_ONE_GBS; rbw = BW_ONE_GBS; len_cap = 8192; step_cap = 9000;
				end
				1: begin
					wbw = rand_bandwidth(231); rbw = rand_bandwidth(231);
					len_cap = 1 << 20; step_cap = 2000000;
				end
				2: begin
					wbw = 40'd1; rbw = 40'd1; len_cap = 255; step_cap = 1000000000;
				end
				3: begin
					wbw = BW_TOP; rbw = BW_TOP; len_cap = 32'hFFFF_FFFF; step_cap = 4000000;
				end
				4: begin
					wbw = '0; rbw = rand_bandwidth(255); len_cap = 65535; step_cap = 100000;
				end
				default: begin
					wbw = rand_bandwidth(255); rbw = BW_ONE_GBS;
					len_cap = 32'hFFFF_FFFF; step_cap = 5000000;
				end
			endcase
			configure(wbw, rbw);
			// first phase runs flat out on both sides
			steady = (ph == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold off mid-phase until the pipe has returned everything
				if (ph == 1 && i == PHASE_ITEMS / 2) drain();
				op = bpd_pkg::op_t'($urandom_range(3));
				// mostly a clock moving forward, now and then a jump anywhere
				if ($urandom_range(15) == 0) begin
					hi = $urandom();
					clock_ns = {hi[30:0], 32'($urandom())};
				end else begin
					clock_ns = clock_ns + $urandom_range(step_cap);
				end
				case ($urandom_range(15))
					0: len = '0;
					1: len = '1;
					2, 3: len = $urandom();
					default: len = $urandom_range(len_cap);
				endcase
				send_request(op, clock_ns, len);
			end
		end

		drain();
		steady = 1'b0;
		// anything the block emits now is unsolicited and gets flagged
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!sb.failed && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* bandwidth_pipe_delay_model.f */
rtl/bpd_pkg.sv
rtl/bpd_div.sv
rtl/bandwidth_pipe_delay_model.sv
bench/bandwidth_pipe_delay_model_test.sv
